// ----- sv/us_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// us_pkg
// shared types and constants of the utf8 sanitizer
// ----------------------------------------------------------------------------
package us_pkg;

  localparam logic [7:0] ReplByte0 = 8'hEF;
  localparam logic [7:0] ReplByte1 = 8'hBF;
  localparam logic [7:0] ReplByte2 = 8'hBD;

  localparam logic [2:0] SeqNone = 3'd0;
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  localparam logic [1:0] ReplLastPhase = 2'd2;

  // one accepted word turns into repl_cnt replacements followed by lit_cnt literals
  typedef struct packed {
    logic [2:0]      repl_cnt;
    logic [2:0]      lit_cnt;
    logic [3:0][7:0] lit;
    logic            fin;
  } plan_t;

  function automatic logic [7:0] repl_byte(input logic [1:0] phase);
    logic [7:0] b;
    unique case (phase)
      2'd0:    b = ReplByte0;
      2'd1:    b = ReplByte1;
      default: b = ReplByte2;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/us_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// us_decode
// sequence tracking and validation; turns each input word into an output plan
// ----------------------------------------------------------------------------
module us_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    in_byte_i,
  input  logic          is_final_i,
  output us_pkg::plan_t plan_o
);

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0]      len_q, len_d;

  logic [20:0] cp;
  logic        cp_ok;
  logic        is_cont;
  logic        seq_open;
  logic        complete;

  assign is_cont  = (in_byte_i[7:6] == 2'b10);
  assign seq_open = (len_q != us_pkg::SeqNone);
  assign complete = ({1'b0, cnt_q} + 3'd1) >= len_q;

  always_comb begin
    unique case (len_q)
      us_pkg::SeqLen2: begin
        cp    = {10'd0, held_q[0][4:0], in_byte_i[5:0]};
        cp_ok = (cp >= 21'h80);
      end
      us_pkg::SeqLen3: begin
        cp    = {5'd0, held_q[0][3:0], held_q[1][5:0], in_byte_i[5:0]};
        cp_ok = (cp >= 21'h800) && !((cp >= 21'hD800) && (cp <= 21'hDFFF));
      end
      default: begin
        cp    = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], in_byte_i[5:0]};
        cp_ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
      end
    endcase
  end

  always_comb begin
    held_d          = held_q;
    cnt_d           = cnt_q;
    len_d           = len_q;
    plan_o.repl_cnt = 3'd0;
    plan_o.lit_cnt  = 3'd0;
    plan_o.lit      = '0;
    plan_o.fin      = is_final_i;

    if (seq_open && is_cont) begin
      if (complete) begin
        if (cp_ok) begin
          plan_o.lit[0]     = held_q[0];
          plan_o.lit[1]     = held_q[1];
          plan_o.lit[2]     = held_q[2];
          plan_o.lit[cnt_q] = in_byte_i;
          plan_o.lit_cnt    = {1'b0, cnt_q} + 3'd1;
        end else begin
          plan_o.repl_cnt = {1'b0, cnt_q} + 3'd1;
        end
        cnt_d = 2'd0;
        len_d = us_pkg::SeqNone;
      end else if (cnt_q != 2'd3) begin
        held_d[cnt_q] = in_byte_i;
        cnt_d         = cnt_q + 2'd1;
      end
    end else begin
      if (seq_open) begin
        plan_o.repl_cnt = {1'b0, cnt_q};
        cnt_d           = 2'd0;
        len_d           = us_pkg::SeqNone;
      end
      priority if (!in_byte_i[7]) begin
        plan_o.lit[0]  = in_byte_i;
        plan_o.lit_cnt = 3'd1;
      end else if (in_byte_i[7:5] == 3'b110) begin
        held_d[0] = in_byte_i;
        cnt_d     = 2'd1;
        len_d     = us_pkg::SeqLen2;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        held_d[0] = in_byte_i;
        cnt_d     = 2'd1;
        len_d     = us_pkg::SeqLen3;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        held_d[0] = in_byte_i;
        cnt_d     = 2'd1;
        len_d     = us_pkg::SeqLen4;
      end else begin
        plan_o.repl_cnt = plan_o.repl_cnt + 3'd1;
      end
    end

    // unfinished sequence at end of text
    if (is_final_i && (len_d != us_pkg::SeqNone)) begin
      plan_o.repl_cnt = plan_o.repl_cnt + {1'b0, cnt_d};
      cnt_d           = 2'd0;
      len_d           = us_pkg::SeqNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      len_q <= us_pkg::SeqNone;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      held_q <= held_d;
    end
  end

endmodule

// ----- sv/us_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// us_emit
// result register; plays out one plan as replacement and literal words
// ----------------------------------------------------------------------------
module us_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  us_pkg::plan_t plan_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          run_last_o,
  output logic          text_last_o
);

  logic            busy_q;
  logic [2:0]      rep_q;
  logic [1:0]      ph_q;
  logic [2:0]      litn_q;
  logic [3:0][7:0] lit_q;
  logic            fin_q;
  logic            last;
  logic            take;

  assign last = ((rep_q == 3'd0) && (litn_q == 3'd1)) ||
                ((rep_q == 3'd1) && (ph_q == us_pkg::ReplLastPhase) && (litn_q == 3'd0));
  assign take = busy_q && out_ready_i;

  assign free_o      = !busy_q || (take && last);
  assign out_valid_o = busy_q;
  assign out_byte_o  = (rep_q != 3'd0) ? us_pkg::repl_byte(ph_q) : lit_q[0];
  assign run_last_o  = last;
  assign text_last_o = last && fin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rep_q  <= 3'd0;
      ph_q   <= 2'd0;
      litn_q <= 3'd0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      rep_q  <= plan_i.repl_cnt;
      ph_q   <= 2'd0;
      litn_q <= plan_i.lit_cnt;
    end else if (take) begin
      if (last) begin
        busy_q <= 1'b0;
      end
      if (rep_q != 3'd0) begin
        if (ph_q == us_pkg::ReplLastPhase) begin
          ph_q  <= 2'd0;
          rep_q <= rep_q - 3'd1;
        end else begin
          ph_q <= ph_q + 2'd1;
        end
      end else begin
        litn_q <= litn_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lit_q <= plan_i.lit;
      fin_q <= plan_i.fin;
    end else if (take && (rep_q == 3'd0)) begin
      lit_q <= {8'd0, lit_q[3:1]};
    end
  end

endmodule

// ----- sv/utf8_sanitizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_sanitizer
// streaming utf-8 scrubber with EF BF BD replacement
// ----------------------------------------------------------------------------
// input channel: in_valid_i/in_ready_o carry one text byte and is_final_i
// per word. output channel: out_valid_o/out_ready_i carry one sanitized byte
// per word, run_last_o on the last byte caused by an input word and
// text_last_o on the last byte of the text.
// an input word is decoded in the cycle it is accepted and its bytes appear
// from the result register in the next cycle.
// throughput: one input word per cycle while each produces at most one byte
// and out_ready_i is high. words with n bytes (up to 12: four replacements)
// occupy the result register, and input stalls until its last byte is taken;
// bytes of an open multi-byte sequence produce nothing until it completes.
// in_ready_o is high when the result register is empty or its last byte is
// being taken this cycle.
// reset clears the open sequence and empties the result register.
// a stalled receiver holds the current byte and backpressures the input.
// ----------------------------------------------------------------------------
module utf8_sanitizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_final_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       text_last_o
);

  us_pkg::plan_t plan;
  logic          accept;
  logic          load;
  logic          free;

  assign in_ready_o = free;
  assign accept     = in_valid_i && free;
  assign load       = accept && ((plan.repl_cnt != 3'd0) || (plan.lit_cnt != 3'd0));

  us_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .is_final_i (is_final_i),
    .plan_o     (plan)
  );

  us_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .plan_i      (plan),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .text_last_o (text_last_o)
  );

endmodule
